// File: rtl/dhci_pkg.sv
// dhci_pkg: shared types, constants and state codes for the deflate hash chain insert block.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package dhci_pkg;

  localparam int HASH_ENTRIES_DEF  = 65536;
  localparam int CHAIN_ENTRIES_DEF = 32768;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [31:0] HASH_MULT   = 32'd2654435761;
  localparam logic [14:0] WMASK_RESET = 15'h7fff;

  typedef struct packed {
    logic [15:0] position;
    logic [31:0] four_bytes;
    logic        last_of_run;
  } in_item_t;

  typedef struct packed {
    logic [15:0] previous_head;
    logic        linked;
    logic [15:0] hash_index;
    logic        last_out;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [15:0] position;
    logic [15:0] hash;
    logic        last;
  } queue_item_t;

  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } back_state_t;

endpackage

// File: rtl/dhci_front.sv
// dhci_front: input stage; multiplicative hash of the four-byte word, registered.
// Depends on dhci_pkg.
module dhci_front #(
  parameter int HASH_ENTRIES = dhci_pkg::HASH_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  dhci_pkg::in_item_t     in_data,
  input  logic                   clearing,
  input  dhci_pkg::queue_status_t q_status,
  output logic                   push,
  output dhci_pkg::queue_item_t  push_item
);

  localparam logic [15:0] HashMask = 16'(HASH_ENTRIES - 1);

  logic [31:0] prod;
  logic        s1_valid;
  logic        accept;

  assign prod      = in_data.four_bytes * dhci_pkg::HASH_MULT;
  assign push      = s1_valid & ~q_status.full;
  assign in_stall  = clearing | (s1_valid & q_status.full);
  assign accept    = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      push_item.position <= in_data.position;
      push_item.hash     <= prod[31:16] & HashMask;
      push_item.last     <= in_data.last_of_run;
    end
  end

endmodule

// File: rtl/dhci_fifo.sv
// dhci_fifo: short queue of classified items between front and back.
// Depends on dhci_pkg.
module dhci_fifo (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  dhci_pkg::queue_item_t   push_item,
  input  logic                    pop,
  output dhci_pkg::queue_item_t   head_item,
  output dhci_pkg::queue_status_t status
);

  localparam int Depth = dhci_pkg::QUEUE_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  dhci_pkg::queue_item_t entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign head_item    = entries[rd_ptr];
  assign status.valid = count != '0;
  assign status.full  = count == CntW'(Depth);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// File: rtl/dhci_back.sv
// dhci_back: head table lookup and update, chain store write, result register.
// Depends on dhci_pkg; owns the head table and chain store memories.
module dhci_back #(
  parameter int HASH_ENTRIES  = dhci_pkg::HASH_ENTRIES_DEF,
  parameter int CHAIN_ENTRIES = dhci_pkg::CHAIN_ENTRIES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic [14:0]             cfg_data,
  input  dhci_pkg::queue_status_t q_status,
  input  dhci_pkg::queue_item_t   head_item,
  output logic                    pop,
  output logic                    clearing,
  output logic                    out_valid,
  input  logic                    out_stall,
  output dhci_pkg::out_item_t     out_data
);

  localparam int HashBits  = $clog2(HASH_ENTRIES);
  localparam int ChainBits = $clog2(CHAIN_ENTRIES);

  logic [15:0] head_mem  [HASH_ENTRIES];
  logic [15:0] chain_mem [CHAIN_ENTRIES];

  dhci_pkg::back_state_t state, state_next;
  dhci_pkg::queue_item_t cur;
  logic [HashBits-1:0]   clr_addr;
  logic [14:0]           window_mask;
  logic [15:0]           rd_data;
  logic                  out_taken;
  logic                  do_link;
  logic                  hd_we;
  logic [HashBits-1:0]   hd_waddr;
  logic [15:0]           hd_wdata;
  logic                  ch_we;
  logic                  load_out;
  logic [ChainBits-1:0]  ch_addr;

  assign out_taken = out_valid & ~out_stall;
  assign do_link   = rd_data != cur.position;
  assign ch_addr   = cur.position[ChainBits-1:0] & window_mask[ChainBits-1:0];
  assign clearing  = state == dhci_pkg::ST_CLEAR;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dhci_pkg::ST_CLEAR;
      clr_addr    <= '0;
      window_mask <= dhci_pkg::WMASK_RESET;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == dhci_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cfg_valid) begin
        window_mask <= cfg_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_taken) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    hd_we      = 1'b0;
    hd_waddr   = cur.hash[HashBits-1:0];
    hd_wdata   = cur.position;
    ch_we      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      dhci_pkg::ST_CLEAR: begin
        hd_we    = 1'b1;
        hd_waddr = clr_addr;
        hd_wdata = '0;
        if (clr_addr == {HashBits{1'b1}}) begin
          state_next = dhci_pkg::ST_IDLE;
        end
      end
      dhci_pkg::ST_IDLE: begin
        if (q_status.valid && (!out_valid || out_taken)) begin
          pop        = 1'b1;
          state_next = dhci_pkg::ST_LOOKUP;
        end
      end
      dhci_pkg::ST_LOOKUP: begin
        state_next = dhci_pkg::ST_UPDATE;
      end
      dhci_pkg::ST_UPDATE: begin
        hd_we      = do_link;
        ch_we      = do_link;
        load_out   = 1'b1;
        state_next = dhci_pkg::ST_IDLE;
      end
      default: begin
        state_next = dhci_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_item;
    end
    if (load_out) begin
      out_data.previous_head <= rd_data;
      out_data.linked        <= do_link;
      out_data.hash_index    <= cur.hash;
      out_data.last_out      <= cur.last;
    end
  end

  // head table: one read port, one write port; read registered
  always_ff @(posedge clk) begin
    rd_data <= head_mem[cur.hash[HashBits-1:0]];
    if (hd_we) begin
      head_mem[hd_waddr] <= hd_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ch_we) begin
      chain_mem[ch_addr] <= rd_data;
    end
  end

  a_lookup_then_update: assert property (@(posedge clk) disable iff (rst)
    state == dhci_pkg::ST_LOOKUP |=> state == dhci_pkg::ST_UPDATE)
    else $error("lookup not followed by update");

  a_out_free_on_update: assert property (@(posedge clk) disable iff (rst)
    state == dhci_pkg::ST_UPDATE |-> !out_valid)
    else $error("result register busy when a result is produced");

  a_update_fills_out: assert property (@(posedge clk) disable iff (rst)
    state == dhci_pkg::ST_UPDATE |=> out_valid)
    else $error("result not presented after update");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_status.valid && state == dhci_pkg::ST_IDLE)
    else $error("pop from empty queue or outside idle");

endmodule

// File: rtl/deflate_hash_chain_insert.sv
// deflate_hash_chain_insert: top level; hash front, item queue, head/chain back.
// Depends on dhci_pkg, dhci_front, dhci_fifo, dhci_back.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_data  (dhci_pkg::in_item_t)
//   out     | output    | out_valid/out_stall| out_data (dhci_pkg::out_item_t)
//   cfg     | input     | cfg_valid/cfg_ready| cfg_data (window_mask, 15 bits)
//
// The back end handles one item at a time: pop, head table read, update; the
// registered head table read needs its own step. The front registers the hash.
// After reset the head table is cleared entry by entry; in_stall is high
// meanwhile, cfg writes are still taken. A stalled output holds its result
// while up to QUEUE_DEPTH + 1 further items are accepted.
module deflate_hash_chain_insert #(
  parameter int HASH_ENTRIES  = dhci_pkg::HASH_ENTRIES_DEF,
  parameter int CHAIN_ENTRIES = dhci_pkg::CHAIN_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  dhci_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dhci_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [14:0]         cfg_data
);

  logic                    clearing;
  logic                    push;
  logic                    pop;
  dhci_pkg::queue_item_t   push_item;
  dhci_pkg::queue_item_t   head_item;
  dhci_pkg::queue_status_t q_status;

  assign cfg_ready = 1'b1;

  dhci_front #(
    .HASH_ENTRIES(HASH_ENTRIES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .clearing (clearing),
    .q_status (q_status),
    .push     (push),
    .push_item(push_item)
  );

  dhci_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head_item(head_item),
    .status   (q_status)
  );

  dhci_back #(
    .HASH_ENTRIES (HASH_ENTRIES),
    .CHAIN_ENTRIES(CHAIN_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .q_status (q_status),
    .head_item(head_item),
    .pop      (pop),
    .clearing (clearing),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
